// ----- hdl/mke_pkg.sv -----
// Shared types, constants, Morse table and microprogram for the Morse keyer encoder.
// No dependencies; imported by every other file of the block.
package mke_pkg;

	localparam int unsigned DUR_W = 16;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned PC_W = 4;
	localparam int unsigned CNT_W = 3;
	localparam int unsigned PAT_W = 5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DOT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DASH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EGAP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LGAP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WGAP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTRA = 3'd5;

	localparam logic [DUR_W-1:0] RST_DOT = 16'd200;
	localparam logic [DUR_W-1:0] RST_DASH = 16'd600;
	localparam logic [DUR_W-1:0] RST_EGAP = 16'd200;
	localparam logic [DUR_W-1:0] RST_LGAP = 16'd400;
	localparam logic [DUR_W-1:0] RST_WGAP = 16'd800;
	localparam logic [DUR_W-1:0] RST_EXTRA = 16'd200;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_LC_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LC_Z = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_UC_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UC_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_D0 = 8'h30;
	localparam logic [CHAR_W-1:0] CH_D9 = 8'h39;
	localparam logic [CHAR_W-1:0] CASE_FOLD = 8'hDF;
	localparam logic [CNT_W-1:0] MAX_ELEMS = 3'd5;

	// code: [7:5] element count, [4:0] pattern, first element in bit 4, 1 = dash
	localparam logic [7:0] ALPHA_CODE [0:25] = '{
		8'h48, 8'h90, 8'h94, 8'h70, 8'h20, 8'h84, 8'h78, 8'h80, 8'h40, 8'h8E,
		8'h74, 8'h88, 8'h58, 8'h50, 8'h7C, 8'h8C, 8'h9A, 8'h68, 8'h60, 8'h30,
		8'h64, 8'h82, 8'h6C, 8'h92, 8'h96, 8'h98
	};
	localparam logic [7:0] DIGIT_CODE [0:9] = '{
		8'hBF, 8'hAF, 8'hA7, 8'hA3, 8'hA1, 8'hA0, 8'hB0, 8'hB8, 8'hBC, 8'hBE
	};

	// microprogram step addresses
	localparam logic [PC_W-1:0] PC_FETCH = 4'd0;
	localparam logic [PC_W-1:0] PC_IS_SPACE = 4'd1;
	localparam logic [PC_W-1:0] PC_HAS_CODE = 4'd2;
	localparam logic [PC_W-1:0] PC_ELEM_ON = 4'd3;
	localparam logic [PC_W-1:0] PC_ELEM_GAP = 4'd4;
	localparam logic [PC_W-1:0] PC_PEND = 4'd5;
	localparam logic [PC_W-1:0] PC_EXTRA = 4'd6;
	localparam logic [PC_W-1:0] PC_LETTER = 4'd7;
	localparam logic [PC_W-1:0] PC_WORD = 4'd8;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_XFER,
		COND_SPACE,
		COND_NO_CODE,
		COND_MORE,
		COND_NO_PEND
	} cond_t;

	typedef enum logic [2:0] {
		DUR_ELEM,
		DUR_EGAP,
		DUR_EXTRA,
		DUR_LGAP,
		DUR_WORD
	} dur_sel_t;

	typedef struct packed {
		logic load;
		logic emit;
		logic key;
		logic last;
		dur_sel_t dur;
		logic shift;
		logic dec;
		logic set_pend;
		logic clr_pend;
		cond_t cond;
		logic [PC_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		logic xfer_none;
		logic is_space;
		logic no_code;
		logic more;
		logic no_pend;
		logic stall;
	} stat_t;

	typedef struct packed {
		logic [DUR_W-1:0] dot;
		logic [DUR_W-1:0] dash;
		logic [DUR_W-1:0] egap;
		logic [DUR_W-1:0] lgap;
		logic [DUR_W-1:0] wgap;
		logic [DUR_W-1:0] extra;
	} cfg_t;

	typedef struct packed {
		logic have;
		logic space;
		logic [CNT_W-1:0] cnt;
		logic [PAT_W-1:0] pat;
	} lookup_t;

	function automatic lookup_t mke_lookup(input logic [CHAR_W-1:0] ch);
		logic [CHAR_W-1:0] up;
		logic [CHAR_W-1:0] diff;
		logic [7:0] code;
		lookup_t r;
		up = ch;
		code = '0;
		r = '0;
		r.space = (ch == CH_SPACE);
		if (ch >= CH_LC_A && ch <= CH_LC_Z)
			up = ch & CASE_FOLD;
		if (up >= CH_UC_A && up <= CH_UC_Z) begin
			diff = up - CH_UC_A;
			code = ALPHA_CODE[diff[4:0]];
			r.have = 1'b1;
		end else if (up >= CH_D0 && up <= CH_D9) begin
			diff = up - CH_D0;
			code = DIGIT_CODE[diff[3:0]];
			r.have = 1'b1;
		end
		r.cnt = (code[7:5] > MAX_ELEMS) ? MAX_ELEMS : code[7:5];
		r.pat = code[4:0];
		return r;
	endfunction

	function automatic ucode_t mke_rom(input logic [PC_W-1:0] pc);
		ucode_t u;
		u = '{load: 1'b0, emit: 1'b0, key: 1'b0, last: 1'b0, dur: DUR_EGAP,
			shift: 1'b0, dec: 1'b0, set_pend: 1'b0, clr_pend: 1'b0,
			cond: COND_NEVER, target: PC_FETCH};
		unique case (pc)
			PC_FETCH: begin
				u.load = 1'b1;
				u.cond = COND_NO_XFER;
				u.target = PC_FETCH;
			end
			PC_IS_SPACE: begin
				u.cond = COND_SPACE;
				u.target = PC_WORD;
			end
			PC_HAS_CODE: begin
				u.cond = COND_NO_CODE;
				u.target = PC_LETTER;
			end
			PC_ELEM_ON: begin
				u.emit = 1'b1;
				u.key = 1'b1;
				u.dur = DUR_ELEM;
				u.shift = 1'b1;
			end
			PC_ELEM_GAP: begin
				u.emit = 1'b1;
				u.dur = DUR_EGAP;
				u.dec = 1'b1;
				u.cond = COND_MORE;
				u.target = PC_ELEM_ON;
			end
			PC_PEND: begin
				u.cond = COND_NO_PEND;
				u.target = PC_LETTER;
			end
			PC_EXTRA: begin
				u.emit = 1'b1;
				u.dur = DUR_EXTRA;
				u.clr_pend = 1'b1;
			end
			PC_LETTER: begin
				u.emit = 1'b1;
				u.last = 1'b1;
				u.dur = DUR_LGAP;
				u.cond = COND_ALWAYS;
				u.target = PC_FETCH;
			end
			PC_WORD: begin
				u.emit = 1'b1;
				u.dur = DUR_WORD;
				u.set_pend = 1'b1;
				u.cond = COND_ALWAYS;
				u.target = PC_LETTER;
			end
			default: begin
				u.cond = COND_ALWAYS;
				u.target = PC_FETCH;
			end
		endcase
		return u;
	endfunction

endpackage

// ----- hdl/mke_cfg.sv -----
// Configuration register file for the Morse keyer encoder: six duration registers.
// Depends on mke_pkg.
module mke_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mke_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mke_pkg::DUR_W-1:0]     cfg_data,
	output mke_pkg::cfg_t                 cfg
);
	import mke_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	// indexes past the last register are accepted and dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{dot: RST_DOT, dash: RST_DASH, egap: RST_EGAP,
				lgap: RST_LGAP, wgap: RST_WGAP, extra: RST_EXTRA};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DOT:   cfg_q.dot <= cfg_data;
				CFG_DASH:  cfg_q.dash <= cfg_data;
				CFG_EGAP:  cfg_q.egap <= cfg_data;
				CFG_LGAP:  cfg_q.lgap <= cfg_data;
				CFG_WGAP:  cfg_q.wgap <= cfg_data;
				CFG_EXTRA: cfg_q.extra <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ----- hdl/mke_seq.sv -----
// Microprogram sequencer: step counter, control ROM and conditional jump logic.
// Depends on mke_pkg.
module mke_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  mke_pkg::stat_t  stat,
	output mke_pkg::ucode_t ctrl
);
	import mke_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic            jump;

	assign ctrl = mke_rom(pc_q);

	always_comb begin
		unique case (ctrl.cond)
			COND_NEVER:   jump = 1'b0;
			COND_ALWAYS:  jump = 1'b1;
			COND_NO_XFER: jump = stat.xfer_none;
			COND_SPACE:   jump = stat.is_space;
			COND_NO_CODE: jump = stat.no_code;
			COND_MORE:    jump = stat.more;
			COND_NO_PEND: jump = stat.no_pend;
			default:      jump = 1'b1;
		endcase
	end

	// a step that emits holds while the output register is still occupied
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_FETCH;
		end else if (!stat.stall) begin
			pc_q <= jump ? ctrl.target : pc_q + 1'b1;
		end
	end

endmodule

// ----- hdl/mke_dpath.sv -----
// Datapath: character decode, element pattern and count, word flag, output register.
// Depends on mke_pkg; driven by the control word from mke_seq.
module mke_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mke_pkg::ucode_t            ctrl,
	input  mke_pkg::cfg_t              cfg,
	input  logic                       in_valid,
	input  logic [mke_pkg::CHAR_W-1:0] char_code,
	output mke_pkg::stat_t             stat,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       key_on,
	output logic [mke_pkg::DUR_W-1:0]  seg_duration,
	output logic                       last_segment
);
	import mke_pkg::*;

	lookup_t         lk;
	logic            have_q;
	logic            space_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PAT_W-1:0] pat_q;
	logic            pend_q;
	logic            out_valid_q;
	logic            key_q;
	logic            last_q;
	logic [DUR_W-1:0] dur_q;
	logic [DUR_W-1:0] dur_mux;
	logic            stall;
	logic            advance;

	assign lk = mke_lookup(char_code);
	assign stall = ctrl.emit && out_valid_q && !out_ready;
	assign advance = !stall;

	always_comb begin
		stat.xfer_none = !in_valid;
		stat.is_space = space_q;
		stat.no_code = !have_q;
		stat.more = (cnt_q != CNT_W'(1));
		stat.no_pend = !pend_q;
		stat.stall = stall;
	end

	always_comb begin
		unique case (ctrl.dur)
			DUR_ELEM:  dur_mux = pat_q[PAT_W-1] ? cfg.dash : cfg.dot;
			DUR_EGAP:  dur_mux = cfg.egap;
			DUR_EXTRA: dur_mux = cfg.extra;
			DUR_LGAP:  dur_mux = cfg.lgap;
			DUR_WORD:  dur_mux = cfg.wgap;
			default:   dur_mux = cfg.lgap;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.load && in_valid) begin
			have_q <= lk.have;
			space_q <= lk.space;
			cnt_q <= lk.cnt;
			pat_q <= lk.pat;
		end else if (advance) begin
			if (ctrl.shift)
				pat_q <= {pat_q[PAT_W-2:0], 1'b0};
			if (ctrl.dec)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (advance) begin
			if (ctrl.set_pend)
				pend_q <= 1'b1;
			else if (ctrl.clr_pend)
				pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit && advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit && advance) begin
			key_q <= ctrl.key;
			last_q <= ctrl.last;
			dur_q <= dur_mux;
		end
	end

	assign out_valid = out_valid_q;
	assign key_on = key_q;
	assign seg_duration = dur_q;
	assign last_segment = last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(dur_q) && $stable(key_q)))
		else $error("pending segment overwritten");

	a_pend_set: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.set_pend && advance) |=> pend_q)
		else $error("word flag not set after word gap");

	a_elem_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.emit && ctrl.dur == DUR_ELEM) |-> (have_q && cnt_q != '0))
		else $error("element emitted with no element left");

	a_key_only_elem: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && key_q) |-> !last_q)
		else $error("key-on segment marked last");

endmodule

// ----- hdl/morse_keyer_encoder.sv -----
// Morse keyer encoder: takes one ASCII character per transfer and sends its keying
// segments (level, duration, last flag) one per transfer on the output channel.
//
// Channels: in_valid/in_ready with char_code; out_valid/out_ready with key_on,
// seg_duration and last_segment; cfg_valid/cfg_ready with cfg_index and cfg_data
// writing one of six 16-bit duration registers (dot, dash, element gap, letter gap,
// word gap, first-letter extra). cfg_ready is always high; unknown indexes are dropped.
// Configuration must be written only while no character is in flight; not enforced.
//
// A microprogram of nine steps handles each character: one fetch step, up to two
// dispatch steps, then one step per emitted segment, plus one check step for the word
// flag on letters and digits. A new character is accepted only at the fetch step,
// after the letter gap of the previous character has been issued. Each segment step
// issues one segment into a single output register.
//
// Reset (arst_n low) returns the durations to their defaults, clears the word flag,
// empties the output register and restarts the program at the fetch step. When the
// receiver holds out_ready low with the output register full, the step that wants to
// issue a segment waits and the whole sequencer holds; no segment is lost or repeated.
module morse_keyer_encoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mke_pkg::CHAR_W-1:0]    char_code,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          key_on,
	output logic [mke_pkg::DUR_W-1:0]     seg_duration,
	output logic                          last_segment,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mke_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mke_pkg::DUR_W-1:0]     cfg_data
);
	import mke_pkg::*;

	cfg_t   cfg;
	ucode_t ctrl;
	stat_t  stat;

	assign in_ready = ctrl.load;

	mke_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mke_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	mke_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.char_code    (char_code),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.key_on       (key_on),
		.seg_duration (seg_duration),
		.last_segment (last_segment)
	);

endmodule
